// ===== src/lmts_pkg.sv =====
// lmts_pkg: shared types, constants and the mode length table
// for the lcd mode timing sequencer; no dependencies
package lmts_pkg;

    localparam int STEP_W     = 6;
    localparam int LINE_W     = 8;
    localparam int CLOCK_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam int VISIBLE_LINES_DEF = 144;
    localparam logic [LINE_W-1:0] LAST_LINE = 8'd153;

    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_OAM      = 2'd2,
        MODE_TRANSFER = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DOUBLE_SPEED = 3'd0,
        CFG_LINE_COMPARE = 3'd1,
        CFG_HBLANK_STAT  = 3'd2,
        CFG_VBLANK_STAT  = 3'd3,
        CFG_OAM_STAT     = 3'd4,
        CFG_MATCH_STAT   = 3'd5,
        CFG_VBLANK_IRQ   = 3'd6
    } t_cfg_index;

    typedef struct packed {
        logic              double_speed;
        logic [LINE_W-1:0] line_compare;
        logic              hblank_stat_enable;
        logic              vblank_stat_enable;
        logic              oam_stat_enable;
        logic              match_stat_enable;
        logic              vblank_irq_allowed;
    } t_cfg;

    typedef struct packed {
        t_mode             cur_mode;
        logic [LINE_W-1:0] cur_line;
        logic              line_match;
        logic              stat_irq;
        logic              vblank_irq;
        logic              render_line;
        logic              frame_done;
    } t_result;

    function automatic logic [CLOCK_W-1:0] mode_len(input logic speed, input t_mode mode);
        logic [CLOCK_W-1:0] len;
        case (mode)
            MODE_HBLANK:   len = speed ? 10'd408 : 10'd204;
            MODE_VBLANK:   len = speed ? 10'd912 : 10'd456;
            MODE_OAM:      len = speed ? 10'd164 : 10'd80;
            MODE_TRANSFER: len = speed ? 10'd344 : 10'd172;
            default:       len = 10'd0;
        endcase
        return len;
    endfunction

endpackage

// ===== src/lmts_cfg_regs.sv =====
// lmts_cfg_regs: configuration register file written through the plain write port
// depends on lmts_pkg
module lmts_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [lmts_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lmts_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output lmts_pkg::t_cfg                   o_cfg
);

    lmts_pkg::t_cfg r_cfg;
    lmts_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                lmts_pkg::CFG_DOUBLE_SPEED: n_cfg.double_speed       = i_cfg_wdata[0];
                lmts_pkg::CFG_LINE_COMPARE: n_cfg.line_compare       = i_cfg_wdata;
                lmts_pkg::CFG_HBLANK_STAT:  n_cfg.hblank_stat_enable = i_cfg_wdata[0];
                lmts_pkg::CFG_VBLANK_STAT:  n_cfg.vblank_stat_enable = i_cfg_wdata[0];
                lmts_pkg::CFG_OAM_STAT:     n_cfg.oam_stat_enable    = i_cfg_wdata[0];
                lmts_pkg::CFG_MATCH_STAT:   n_cfg.match_stat_enable  = i_cfg_wdata[0];
                lmts_pkg::CFG_VBLANK_IRQ:   n_cfg.vblank_irq_allowed = i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/lmts_mode_core.sv =====
// lmts_mode_core: mode clock, mode and line state with the per-tick update logic
// depends on lmts_pkg
module lmts_mode_core #(
    parameter int VISIBLE_LINES = lmts_pkg::VISIBLE_LINES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [lmts_pkg::STEP_W-1:0]   i_step_clocks,
    input  lmts_pkg::t_cfg                i_cfg,
    output lmts_pkg::t_result             o_result
);

    localparam int SUM_W = lmts_pkg::CLOCK_W + 1;

    lmts_pkg::t_mode                 r_mode;
    lmts_pkg::t_mode                 n_mode;
    logic [lmts_pkg::LINE_W-1:0]     r_line;
    logic [lmts_pkg::LINE_W-1:0]     n_line;
    logic [lmts_pkg::CLOCK_W-1:0]    r_clock;
    logic [lmts_pkg::CLOCK_W-1:0]    n_clock;

    logic [lmts_pkg::CLOCK_W-1:0]    len;
    logic [SUM_W-1:0]                sum;
    logic [SUM_W-1:0]                rem;
    logic                            hit;
    logic [lmts_pkg::LINE_W-1:0]     line_inc;
    logic                            entered;
    logic                            line_step;
    logic                            render;
    logic                            frame;
    logic                            stat;
    logic                            vblank;

    assign len      = lmts_pkg::mode_len(i_cfg.double_speed, r_mode);
    assign sum      = {1'b0, r_clock} + {{(SUM_W - lmts_pkg::STEP_W){1'b0}}, i_step_clocks};
    assign rem      = sum - {1'b0, len};
    assign hit      = (sum >= {1'b0, len});
    assign n_clock  = hit ? rem[lmts_pkg::CLOCK_W-1:0] : sum[lmts_pkg::CLOCK_W-1:0];
    assign line_inc = r_line + 8'd1;

    // next state
    always_comb begin
        n_mode    = r_mode;
        n_line    = r_line;
        entered   = 1'b0;
        line_step = 1'b0;
        render    = 1'b0;
        frame     = 1'b0;
        if (hit) begin
            case (r_mode)
                lmts_pkg::MODE_OAM: begin
                    n_mode  = lmts_pkg::MODE_TRANSFER;
                    entered = 1'b1;
                end
                lmts_pkg::MODE_TRANSFER: begin
                    n_mode  = lmts_pkg::MODE_HBLANK;
                    entered = 1'b1;
                    render  = 1'b1;
                end
                lmts_pkg::MODE_HBLANK: begin
                    n_line    = line_inc;
                    line_step = 1'b1;
                    entered   = 1'b1;
                    if (line_inc == lmts_pkg::LINE_W'(VISIBLE_LINES)) begin
                        n_mode = lmts_pkg::MODE_VBLANK;
                        frame  = 1'b1;
                    end else begin
                        n_mode = lmts_pkg::MODE_OAM;
                    end
                end
                default: begin
                    line_step = 1'b1;
                    if (r_line >= lmts_pkg::LAST_LINE) begin
                        n_line  = '0;
                        n_mode  = lmts_pkg::MODE_OAM;
                        entered = 1'b1;
                    end else begin
                        n_line = line_inc;
                    end
                end
            endcase
        end
    end

    // interrupt outputs
    always_comb begin
        stat   = 1'b0;
        vblank = 1'b0;
        if (entered) begin
            case (n_mode)
                lmts_pkg::MODE_HBLANK: stat = i_cfg.hblank_stat_enable;
                lmts_pkg::MODE_VBLANK: begin
                    stat   = i_cfg.vblank_stat_enable;
                    vblank = i_cfg.vblank_irq_allowed;
                end
                lmts_pkg::MODE_OAM:    stat = i_cfg.oam_stat_enable;
                default:               stat = 1'b0;
            endcase
        end
        if (line_step && i_cfg.match_stat_enable && (n_line == i_cfg.line_compare)) begin
            stat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= lmts_pkg::MODE_VBLANK;
            r_line  <= '0;
            r_clock <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_clock <= n_clock;
        end
    end

    assign o_result.cur_mode    = n_mode;
    assign o_result.cur_line    = n_line;
    assign o_result.line_match  = (n_line == i_cfg.line_compare);
    assign o_result.stat_irq    = stat;
    assign o_result.vblank_irq  = vblank;
    assign o_result.render_line = render;
    assign o_result.frame_done  = frame;

endmodule

// ===== src/lmts_out_stage.sv =====
// lmts_out_stage: result register with valid/ready output handshake
// depends on lmts_pkg
module lmts_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  lmts_pkg::t_result  i_result,
    input  logic               i_ready,
    output logic               o_valid,
    output lmts_pkg::t_result  o_result,
    output logic               o_can_load
);

    logic              r_valid;
    lmts_pkg::t_result r_result;

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== src/lcd_mode_timing_sequencer_unit.sv =====
// lcd_mode_timing_sequencer_unit: top level with input register, mode core and result register
// depends on lmts_pkg, lmts_cfg_regs, lmts_mode_core, lmts_out_stage
//
// Each accepted tick adds its step count to the mode clock and advances the lcd mode
// (oam search, transfer, hblank, vblank) and the line counter 0..153, flagging status and
// vblank interrupts, line render and frame done. One tick is accepted every cycle unless output
// back-pressure stalls; a tick passes the input register and then the result register. The rate
// is set by the mode clock add and compare closing the state loop. Configuration writes take
// effect on the next cycle; the user must make them while no tick is in flight, not enforced.
module lcd_mode_timing_sequencer_unit #(
    parameter int VISIBLE_LINES = lmts_pkg::VISIBLE_LINES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [lmts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lmts_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [lmts_pkg::STEP_W-1:0]     i_step_clocks,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [1:0]                      o_cur_mode,
    output logic [lmts_pkg::LINE_W-1:0]     o_cur_line,
    output logic                            o_line_match,
    output logic                            o_stat_irq,
    output logic                            o_vblank_irq,
    output logic                            o_render_line,
    output logic                            o_frame_done
);

    lmts_pkg::t_cfg              cfg;
    lmts_pkg::t_result           core_result;
    lmts_pkg::t_result           out_result;
    logic                        r_in_valid;
    logic [lmts_pkg::STEP_W-1:0] r_in_step;
    logic                        out_can_load;
    logic                        advance;
    logic                        in_xfer;

    assign advance = r_in_valid && out_can_load;
    assign o_ready = !r_in_valid || advance;
    assign in_xfer = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_step <= i_step_clocks;
        end
    end

    lmts_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    lmts_mode_core #(
        .VISIBLE_LINES (VISIBLE_LINES)
    ) u_mode_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (advance),
        .i_step_clocks (r_in_step),
        .i_cfg         (cfg),
        .o_result      (core_result)
    );

    lmts_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_result   (core_result),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_result   (out_result),
        .o_can_load (out_can_load)
    );

    assign o_cur_mode    = out_result.cur_mode;
    assign o_cur_line    = out_result.cur_line;
    assign o_line_match  = out_result.line_match;
    assign o_stat_irq    = out_result.stat_irq;
    assign o_vblank_irq  = out_result.vblank_irq;
    assign o_render_line = out_result.render_line;
    assign o_frame_done  = out_result.frame_done;

endmodule
